>>> sv/prr43_pkg.sv
package prr43_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TABLE_BITS  = 24;
    localparam int UP_FACTOR   = 4;
    localparam int TAP_COUNT   = 60;
    localparam int LINE_DEPTH  = TAP_COUNT / UP_FACTOR;
    localparam int PHASES      = UP_FACTOR;
    localparam int ACC_GUARD   = 4;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_AW     = 3;

    localparam int PH0 = 0;
    localparam int PH1 = 1;
    localparam int PH2 = 2;
    localparam int PH3 = 3;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // half of the symmetric prototype, gain of four folded in, Q1.23
    localparam int HALF_TABLE [TAP_COUNT/2] = '{
        -399906,   55514,  168640,  268478,  272472,
         147322,  -60015, -238302, -271645, -113422,
         165224,  404944,  439466,  204322, -203600,
        -556918, -616506, -281324,  318503,  855098,
         962202,  454336, -516120, -1461394, -1746775,
        -892511, 1155222, 3926016, 6566589, 8174376
    };

    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_THIRD
    } frame_pos_t;

    typedef struct packed {
        logic first_half;   // phases 0 and 1
        logic second_half;  // phases 2 and 3
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0] count;  // words pushed this cycle, 0 to 2
    } push_ctrl_t;

    // coefficient k reduced to Q1.(cbits-1), round half up
    function automatic int coef_value(input int k, input int cbits);
        int idx;
        int base;
        int sh;
        idx  = (k < TAP_COUNT/2) ? k : (TAP_COUNT - 1 - k);
        base = HALF_TABLE[idx];
        sh   = TABLE_BITS - cbits;
        if (sh == 0) begin
            return base;
        end
        return (base + (1 <<< (sh - 1))) >>> sh;
    endfunction

endpackage

>>> sv/polyphase_resampler_4_3_top.sv
// channel | dir | tdata (low bit up) | tuser       | tlast
// s_      | in  | sample_in [15:0]   | frame_start | frame_end
// m_      | out | sample_out [15:0]  | -           | run_last
//
// An input word is applied in two halves: each of the 15 cells has two
// multipliers, phases 0/1 update on the accept edge, 2/3 on the next.
// Output words of an input are pushed from cap_valid_reg into the queue.
// Reset clears the partial sums (an all-zero delay line), position and queue.
// s_tready drops while the 8-word output queue cannot take two more words.
module polyphase_resampler_4_3_top #(
    parameter int COEF_BITS = 18
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [prr43_pkg::SAMPLE_BITS-1:0]  s_tdata,   // sample_in
    input  logic                               s_tuser,   // frame_start
    input  logic                               s_tlast,   // frame_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [prr43_pkg::SAMPLE_BITS-1:0]  m_tdata,   // sample_out
    output logic                               m_tlast    // run_last
);
    import prr43_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + ACC_GUARD;

    logic                          in_fire;
    logic                          room;
    logic signed [SAMPLE_BITS-1:0] x_bcast;
    cell_ctrl_t                    cell_ctrl;
    logic [PHASES-1:0][ACC_W-1:0]  chain [LINE_DEPTH+1];
    push_ctrl_t                    push;
    logic [1:0][ACC_W-1:0]         raw;

    logic                          phase_b_reg;
    logic                          cap_valid_reg;
    frame_pos_t                    frame_pos_reg, frame_pos_next;
    frame_pos_t                    pos_sel;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    frame_pos_t                    cur_pos_reg;
    logic                          cur_end_reg;
    frame_pos_t                    cap_pos_reg;
    logic                          cap_end_reg;

    assign s_tready = !phase_b_reg && room;
    assign in_fire  = s_tvalid && s_tready;

    assign x_bcast               = phase_b_reg ? x_reg : $signed(s_tdata);
    assign cell_ctrl.first_half  = in_fire;
    assign cell_ctrl.second_half = phase_b_reg;

    assign pos_sel = s_tuser ? POS_FIRST : frame_pos_reg;

    always_comb begin
        unique case (pos_sel)
            POS_FIRST:  frame_pos_next = POS_SECOND;
            POS_SECOND: frame_pos_next = POS_THIRD;
            POS_THIRD:  frame_pos_next = POS_FIRST;
            default:    frame_pos_next = POS_SECOND;
        endcase
    end

    assign chain[LINE_DEPTH] = '0;

    for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
        prr43_cell #(
            .CELL_INDEX (i),
            .COEF_BITS  (COEF_BITS),
            .ACC_W      (ACC_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .x       (x_bcast),
            .sum_in  (chain[i+1]),
            .sum_out (chain[i])
        );
    end

    // pick the finished phase sums of the word completed last cycle
    always_comb begin
        push.count = 2'd0;
        raw[0]     = chain[0][PH0];
        raw[1]     = chain[0][PH3];
        if (cap_valid_reg) begin
            unique case (cap_pos_reg)
                POS_SECOND: begin
                    raw[0]     = chain[0][PH2];
                    push.count = cap_end_reg ? 2'd0 : 2'd1;
                end
                POS_THIRD: begin
                    raw[0]     = chain[0][PH1];
                    push.count = 2'd1;
                end
                default: begin
                    push.count = cap_end_reg ? 2'd1 : 2'd2;
                end
            endcase
        end
    end

    prr43_outbuf #(
        .COEF_BITS (COEF_BITS),
        .ACC_W     (ACC_W)
    ) u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .raw      (raw),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_b_reg   <= 1'b0;
            cap_valid_reg <= 1'b0;
            frame_pos_reg <= POS_FIRST;
        end else begin
            phase_b_reg   <= in_fire;
            cap_valid_reg <= phase_b_reg;
            if (in_fire) begin
                frame_pos_reg <= frame_pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            x_reg       <= $signed(s_tdata);
            cur_pos_reg <= pos_sel;
            cur_end_reg <= s_tlast;
        end
        if (phase_b_reg) begin
            cap_pos_reg <= cur_pos_reg;
            cap_end_reg <= cur_end_reg;
        end
    end

endmodule

>>> sv/prr43_cell.sv
module prr43_cell #(
    parameter int CELL_INDEX = 0,
    parameter int COEF_BITS  = 18,
    parameter int ACC_W      = 38
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  prr43_pkg::cell_ctrl_t                           ctrl,
    input  logic signed [prr43_pkg::SAMPLE_BITS-1:0]        x,
    input  logic [prr43_pkg::PHASES-1:0][ACC_W-1:0]         sum_in,
    output logic [prr43_pkg::PHASES-1:0][ACC_W-1:0]         sum_out
);
    import prr43_pkg::*;

    localparam int K0 = CELL_INDEX * UP_FACTOR;
    localparam logic signed [COEF_BITS-1:0] C0 = COEF_BITS'(coef_value(K0 + PH0, COEF_BITS));
    localparam logic signed [COEF_BITS-1:0] C1 = COEF_BITS'(coef_value(K0 + PH1, COEF_BITS));
    localparam logic signed [COEF_BITS-1:0] C2 = COEF_BITS'(coef_value(K0 + PH2, COEF_BITS));
    localparam logic signed [COEF_BITS-1:0] C3 = COEF_BITS'(coef_value(K0 + PH3, COEF_BITS));

    logic signed [COEF_BITS-1:0]             coef_m0;
    logic signed [COEF_BITS-1:0]             coef_m1;
    logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_m0;
    logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_m1;
    logic [PHASES-1:0][ACC_W-1:0]            sum_reg;
    logic [PHASES-1:0][ACC_W-1:0]            sum_next;

    // m0 serves phases 0 and 2, m1 phases 1 and 3
    assign coef_m0 = ctrl.second_half ? C2 : C0;
    assign coef_m1 = ctrl.second_half ? C3 : C1;
    assign prod_m0 = x * coef_m0;
    assign prod_m1 = x * coef_m1;

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.first_half) begin
            sum_next[PH0] = ACC_W'(prod_m0) + sum_in[PH0];
            sum_next[PH1] = ACC_W'(prod_m1) + sum_in[PH1];
        end
        if (ctrl.second_half) begin
            sum_next[PH2] = ACC_W'(prod_m0) + sum_in[PH2];
            sum_next[PH3] = ACC_W'(prod_m1) + sum_in[PH3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

>>> sv/prr43_outbuf.sv
module prr43_outbuf #(
    parameter int COEF_BITS = 18,
    parameter int ACC_W     = 38
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  prr43_pkg::push_ctrl_t                  push,
    input  logic [1:0][ACC_W-1:0]                  raw,
    output logic                                   room,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [prr43_pkg::SAMPLE_BITS-1:0]      m_tdata,
    output logic                                   m_tlast
);
    import prr43_pkg::*;

    localparam int SHIFT = COEF_BITS - 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(2**(SAMPLE_BITS-1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO     = ~SAT_HI;

    typedef struct packed {
        logic                   last;
        logic [SAMPLE_BITS-1:0] data;
    } out_word_t;

    logic signed [ACC_W-1:0] biased [2];
    logic signed [ACC_W-1:0] scaled [2];
    out_word_t               word   [2];

    out_word_t          mem_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_AW:0]   count_reg, count_next;
    logic [OUTQ_AW+1:0] level_ahead;
    logic               pop;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            biased[i] = $signed(raw[i]) + ROUND_HALF;
            scaled[i] = biased[i] >>> SHIFT;
            if (scaled[i] > SAT_HI) begin
                word[i].data = SAMPLE_MAX;
            end else if (scaled[i] < SAT_LO) begin
                word[i].data = SAMPLE_MIN;
            end else begin
                word[i].data = scaled[i][SAMPLE_BITS-1:0];
            end
        end
        word[0].last = (push.count == 2'd1);
        word[1].last = 1'b1;
    end

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg].data;
    assign m_tlast  = mem_reg[rd_ptr_reg].last;

    // room for the pending push plus a full pair from the next word accepted
    assign level_ahead = (OUTQ_AW+2)'(count_reg) + (OUTQ_AW+2)'(push.count)
                       + (OUTQ_AW+2)'(2);
    assign room        = (level_ahead <= (OUTQ_AW+2)'(OUTQ_DEPTH));

    assign wr_ptr_next = wr_ptr_reg + OUTQ_AW'(push.count);
    assign rd_ptr_next = rd_ptr_reg + OUTQ_AW'(pop);
    assign count_next  = count_reg + (OUTQ_AW+1)'(push.count) - (OUTQ_AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= word[0];
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + OUTQ_AW'(1)] <= word[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/prr43_checker.sv
module prr43_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [prr43_pkg::SAMPLE_BITS-1:0]  s_tdata,
    input logic                               s_tuser,
    input logic                               s_tlast,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [prr43_pkg::SAMPLE_BITS-1:0]  m_tdata,
    input logic                               m_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a waiting input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata)
                                  && $stable(s_tuser) && $stable(s_tlast))
        else $error("input word changed while waiting");

    // second half of the cell update blocks the input in the cycle after an accept
    a_in_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken during second half of update");

    // a pair is queued together, so its last word follows at once
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("pair broken in output queue");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind polyphase_resampler_4_3_top prr43_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    import prr43_pkg::*;

    localparam int COEF_W       = 18;
    localparam int ITEM_GOAL    = 1650;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PRINT_LIMIT  = 50;
    localparam logic [15:0] FULL_POS = 16'h7fff;
    localparam logic [15:0] FULL_NEG = 16'h8000;

    // half of the symmetric prototype, 4*h[k] in Q1.23
    localparam int PROTO_HALF [30] = '{
        -399906,   55514,  168640,  268478,  272472,
         147322,  -60015, -238302, -271645, -113422,
         165224,  404944,  439466,  204322, -203600,
        -556918, -616506, -281324,  318503,  855098,
         962202,  454336, -516120, -1461394, -1746775,
        -892511, 1155222, 3926016, 6566589, 8174376
    };

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } out_word_t;

    class resampler_scoreboard;
        logic signed [15:0] history [LINE_DEPTH];
        frame_pos_t         position;
        out_word_t          expected_words [$];
        int                 mismatches;

        function new();
            foreach (history[n]) history[n] = '0;
            position   = POS_FIRST;
            mismatches = 0;
        endfunction

        // 4*h[k] reduced to Q1.(COEF_W-1), half an LSB added then floored
        function int coef(int k);
            int base;
            base = (k < TAP_COUNT/2) ? PROTO_HALF[k] : PROTO_HALF[TAP_COUNT-1-k];
            return (base + (1 <<< (TABLE_BITS - COEF_W - 1))) >>> (TABLE_BITS - COEF_W);
        endfunction

        function logic [15:0] phase_sum(int phase);
            longint acc;
            acc = 0;
            for (int n = 0; n < LINE_DEPTH; n++)
                acc += longint'(history[n]) * longint'(coef(n * UP_FACTOR + phase));
            acc = (acc + (longint'(1) <<< (COEF_W - 2))) >>> (COEF_W - 1);
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
            return acc[15:0];
        endfunction

        function void push_word(logic [15:0] s, logic last);
            out_word_t w;
            w.sample = s;
            w.last   = last;
            expected_words.push_back(w);
        endfunction

        function void take_sample(logic [15:0] s, logic frame_first, logic frame_last);
            frame_pos_t pos;
            for (int n = LINE_DEPTH - 1; n > 0; n--)
                history[n] = history[n-1];
            history[0] = s;
            pos = frame_first ? POS_FIRST : position;
            position = (pos == POS_THIRD) ? POS_FIRST : frame_pos_t'(pos + 1);
            case (pos)
                POS_FIRST: begin
                    push_word(phase_sum(PH0), frame_last);
                    if (!frame_last)
                        push_word(phase_sum(PH3), 1'b1);
                end
                POS_SECOND: begin
                    if (!frame_last)
                        push_word(phase_sum(PH2), 1'b1);
                end
                default: begin
                    push_word(phase_sum(PH1), 1'b1);
                end
            endcase
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("%0t mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_word(logic [15:0] data, logic last);
            out_word_t w;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word %0d", $signed(data)));
            end else begin
                w = expected_words.pop_front();
                if (data !== w.sample)
                    report($sformatf("sample_out %0d, expected %0d",
                                     $signed(data), $signed(w.sample)));
                if (last !== w.last)
                    report($sformatf("run_last %b, expected %b", last, w.last));
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    resampler_scoreboard sb;
    int  sent_count  = 0;
    int  idle_cycles = 0;
    bit  src_calm    = 1'b0;
    bit  sink_calm   = 1'b0;

    always #1 aclk = ~aclk;

    polyphase_resampler_4_3_top #(
        .COEF_BITS(COEF_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // sample_in
        .s_tuser (s_tuser),   // frame_start
        .s_tlast (s_tlast),   // frame_end
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // sample_out
        .m_tlast (m_tlast)    // run_last
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.take_sample(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] random_sample();
        int r;
        logic [15:0] picks [4];
        picks = '{FULL_POS, FULL_NEG, 16'h0000, 16'hffff};
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom());
        if (r < 70)
            return 16'($urandom_range(0, 511) - 256);
        if (r < 85)
            return picks[$urandom_range(0, 3)];
        return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 14'($urandom())};
    endfunction

    task send_sample(input logic [15:0] s, input logic frame_first, input logic frame_last);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tuser  <= frame_first;
        s_tlast  <= frame_last;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task send_frame(input int len, input bit with_start, input bit with_end);
        for (int i = 0; i < len; i++)
            send_sample(random_sample(), with_start && i == 0, with_end && i == len - 1);
    endtask

    // fills the line with full-scale samples signed like the taps of one phase,
    // the last of them landing on the position that produces that phase
    task drive_full_scale(input bit invert, input int phase);
        int pos;
        int c;
        logic [15:0] s;
        pos = (phase == PH1) ? 2 : (phase == PH2) ? 1 : 0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            c = sb.coef((LINE_DEPTH - 1 - i) * UP_FACTOR + phase);
            s = ((c >= 0) ^ invert) ? FULL_POS : FULL_NEG;
            send_sample(s, i == LINE_DEPTH - 1 - pos, 1'b0);
        end
    endtask

    initial begin
        int gap;
        repeat (2) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                sink_calm = !sink_calm;
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            gap = pick_gap(sink_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        int choice;
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(FULL_POS, 1'b1, 1'b0);
        send_sample(FULL_NEG, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0);
        send_sample(16'hffff, 1'b0, 1'b1);   // end on first position
        send_sample(16'h0001, 1'b0, 1'b1);   // end on second: no word
        send_sample(FULL_POS, 1'b0, 1'b1);   // end on third: unchanged
        send_sample(FULL_NEG, 1'b1, 1'b1);   // start and end together
        send_sample(16'h5555, 1'b0, 1'b0);
        send_sample(16'haaaa, 1'b0, 1'b0);
        send_sample(16'h1234, 1'b0, 1'b0);   // keeps cycling without a start
        drive_full_scale(1'b0, PH0);

        while (sent_count < ITEM_GOAL) begin
            if ($urandom_range(0, 15) == 0)
                src_calm = !src_calm;
            choice = $urandom_range(0, 99);
            if (choice < 78)
                send_frame(($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                        : $urandom_range(13, 40),
                           1'b1, 1'b1);
            else if (choice < 88)
                repeat ($urandom_range(1, 4))
                    send_sample(random_sample(), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
            else if (choice < 94)
                send_frame($urandom_range(1, 12), 1'($urandom_range(0, 1)), 1'b0);
            else
                drive_full_scale(1'($urandom_range(0, 1)), $urandom_range(PH0, PH3));
        end
        s_tvalid <= 1'b0;

        while (sb.expected_words.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
